// File: hdl/hjs_pkg.sv
// shared types and constants for the halton jitter sequence block
package hjs_pkg;

  localparam int IDX_W  = 16;
  localparam int FRAC_W = 24;
  localparam int OFS_W  = 24;
  localparam int DIV_W  = 25;
  localparam int CNT_W  = 5;
  localparam int CFG_W  = 4;
  localparam int DAT_W  = 16;

  typedef enum logic [CFG_W-1:0] {
    CFG_LEN    = 4'd0,
    CFG_BASE_X = 4'd1,
    CFG_BASE_Y = 4'd2,
    CFG_SPREAD = 4'd3,
    CFG_PIN_EN = 4'd4,
    CFG_PIN    = 4'd5,
    CFG_WIDTH  = 4'd6,
    CFG_HEIGHT = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic accept;
    logic zero;
    logic idx_start;
    logic idx_done;
    logic axis_init;
    logic dig_start;
    logic dig_step;
    logic frac_start;
    logic frac_done;
    logic mul;
    logic scale;
    logic ndc_start;
    logic ndc_done;
    logic axis;
  } dp_cmd_t;

  typedef struct packed {
    logic enable;
    logic div_done;
    logic n_zero;
  } dp_stat_t;

endpackage

// File: hdl/hjs_div.sv
// shared restoring divider, one quotient bit per cycle
module hjs_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [hjs_pkg::DIV_W-1:0] rem_init,
  input  logic [hjs_pkg::DIV_W-1:0] dividend,
  input  logic [hjs_pkg::DIV_W-1:0] divisor,
  input  logic [hjs_pkg::CNT_W-1:0] steps,
  output logic                      done,
  output logic [hjs_pkg::DIV_W-1:0] quo,
  output logic [hjs_pkg::DIV_W-1:0] rem
);

  logic [hjs_pkg::DIV_W-1:0] rem_r, dvd_r, quo_r, dsr_r;
  logic [hjs_pkg::CNT_W-1:0] cnt_r;
  logic                      busy_r, done_r;
  logic [hjs_pkg::DIV_W:0]   trial;

  assign trial = {rem_r, dvd_r[hjs_pkg::DIV_W-1]} - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      dvd_r <= dividend;
      dsr_r <= divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[hjs_pkg::DIV_W-2:0], 1'b0};
      if (!trial[hjs_pkg::DIV_W]) begin
        rem_r <= trial[hjs_pkg::DIV_W-1:0];
        quo_r <= {quo_r[hjs_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[hjs_pkg::DIV_W-2:0], dvd_r[hjs_pkg::DIV_W-1]};
        quo_r <= {quo_r[hjs_pkg::DIV_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

// File: hdl/hjs_dp.sv
// datapath: configuration registers, index, digit reversal, scaling and ndc
module hjs_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  hjs_pkg::dp_cmd_t          cmd,
  output hjs_pkg::dp_stat_t         stat,
  input  logic                      cfg_valid,
  input  logic [hjs_pkg::CFG_W-1:0] cfg_index,
  input  logic [hjs_pkg::DAT_W-1:0] cfg_data,
  input  logic                      in_jitter_enable,
  output logic [hjs_pkg::OFS_W-1:0] cur_x,
  output logic [hjs_pkg::OFS_W-1:0] cur_y,
  output logic [hjs_pkg::OFS_W-1:0] prev_x,
  output logic [hjs_pkg::OFS_W-1:0] prev_y,
  output logic [hjs_pkg::OFS_W-1:0] ndc_x,
  output logic [hjs_pkg::OFS_W-1:0] ndc_y
);

  logic [15:0] len_r, spread_r, pin_pos_r, width_r, height_r;
  logic [7:0]  bx_r, by_r;
  logic        pin_en_r;

  logic [hjs_pkg::IDX_W-1:0] idx_r;
  logic [hjs_pkg::IDX_W:0]   n_r, nw_r, idx_inc;
  logic [hjs_pkg::DIV_W-1:0] num_r, den_r;
  logic [hjs_pkg::FRAC_W-1:0] mag_r;
  logic        neg_r, en_r;
  logic [39:0] prod_r;
  logic [hjs_pkg::OFS_W-1:0] cur_x_r, cur_y_r, prev_x_r, prev_y_r, ndc_x_r, ndc_y_r;

  logic [15:0] len_eff, dim_eff;
  logic [7:0]  base_eff, base_sel;
  logic [hjs_pkg::FRAC_W-1:0] h;
  logic [19:0] scaled;
  logic [hjs_pkg::OFS_W-1:0] off_sel, off_abs, off_new, ndc_new;
  logic [20:0] ndc_q;

  logic                      div_start, div_done;
  logic [hjs_pkg::DIV_W-1:0] div_rem0, div_dvd, div_dsr, div_quo, div_rem;
  logic [hjs_pkg::CNT_W-1:0] div_steps;

  localparam logic [hjs_pkg::FRAC_W-1:0] HALF = hjs_pkg::FRAC_W'(1) << (hjs_pkg::FRAC_W - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= 16'd8;
      bx_r      <= 8'd2;
      by_r      <= 8'd3;
      spread_r  <= 16'd4096;
      pin_en_r  <= 1'b0;
      pin_pos_r <= 16'd0;
      width_r   <= 16'd1;
      height_r  <= 16'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        hjs_pkg::CFG_LEN:    len_r     <= cfg_data;
        hjs_pkg::CFG_BASE_X: bx_r      <= cfg_data[7:0];
        hjs_pkg::CFG_BASE_Y: by_r      <= cfg_data[7:0];
        hjs_pkg::CFG_SPREAD: spread_r  <= cfg_data;
        hjs_pkg::CFG_PIN_EN: pin_en_r  <= cfg_data[0];
        hjs_pkg::CFG_PIN:    pin_pos_r <= cfg_data;
        hjs_pkg::CFG_WIDTH:  width_r   <= cfg_data;
        hjs_pkg::CFG_HEIGHT: height_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    len_eff  = (len_r == 16'd0) ? 16'd1 : len_r;
    base_sel = cmd.axis ? by_r : bx_r;
    base_eff = (base_sel < 8'd2) ? 8'd2 : base_sel;
    dim_eff  = cmd.axis ? height_r : width_r;
    if (dim_eff == 16'd0) dim_eff = 16'd1;
    idx_inc  = {1'b0, idx_r} + 1'b1;
    h        = div_quo[hjs_pkg::FRAC_W-1:0];
    scaled   = prod_r[39:20];
    off_new  = neg_r ? -{4'b0, scaled} : {4'b0, scaled};
    off_sel  = cmd.axis ? cur_y_r : cur_x_r;
    off_abs  = off_sel[hjs_pkg::OFS_W-1] ? -off_sel : off_sel;
    ndc_q    = div_quo[20:0];
    ndc_new  = neg_r ? -{3'b0, ndc_q} : {3'b0, ndc_q};
  end

  // divider operand selection
  always_comb begin
    div_start = 1'b0;
    div_rem0  = '0;
    div_dvd   = '0;
    div_dsr   = '0;
    div_steps = '0;
    priority if (cmd.idx_start) begin
      div_start = 1'b1;
      div_dvd   = {(pin_en_r ? {1'b0, pin_pos_r} : idx_inc), 8'b0};
      div_dsr   = {9'b0, len_eff};
      div_steps = 5'd17;
    end else if (cmd.dig_start) begin
      div_start = 1'b1;
      div_dvd   = {nw_r, 8'b0};
      div_dsr   = {17'b0, base_eff};
      div_steps = 5'd17;
    end else if (cmd.frac_start) begin
      div_start = 1'b1;
      div_rem0  = num_r;
      div_dsr   = den_r;
      div_steps = 5'd24;
    end else if (cmd.ndc_start) begin
      div_start = 1'b1;
      div_dvd   = {off_abs[19:0], 5'b0};
      div_dsr   = {9'b0, dim_eff};
      div_steps = 5'd21;
    end
  end

  hjs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .rem_init (div_rem0),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .steps    (div_steps),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      cur_x_r  <= '0;
      cur_y_r  <= '0;
      prev_x_r <= '0;
      prev_y_r <= '0;
      en_r     <= 1'b0;
    end else begin
      if (cmd.accept) begin
        en_r     <= in_jitter_enable;
        prev_x_r <= cur_x_r;
        prev_y_r <= cur_y_r;
      end
      if (cmd.zero) begin
        cur_x_r <= '0;
        cur_y_r <= '0;
      end
      if (cmd.idx_done) idx_r <= div_rem[hjs_pkg::IDX_W-1:0];
      if (cmd.scale) begin
        if (cmd.axis) cur_y_r <= off_new;
        else          cur_x_r <= off_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.zero) begin
      ndc_x_r <= '0;
      ndc_y_r <= '0;
    end
    if (cmd.idx_done) n_r <= {1'b0, div_rem[hjs_pkg::IDX_W-1:0]} + 1'b1;
    if (cmd.axis_init) begin
      nw_r  <= n_r;
      num_r <= '0;
      den_r <= hjs_pkg::DIV_W'(1);
    end
    if (cmd.dig_step) begin
      nw_r  <= div_quo[hjs_pkg::IDX_W:0];
      num_r <= hjs_pkg::DIV_W'(num_r * base_eff + div_rem);
      den_r <= hjs_pkg::DIV_W'(den_r * base_eff);
    end
    if (cmd.frac_done) begin
      neg_r <= (h < HALF);
      mag_r <= (h < HALF) ? HALF - h : h - HALF;
    end
    if (cmd.mul) prod_r <= mag_r * spread_r;
    if (cmd.ndc_done) begin
      if (cmd.axis) ndc_y_r <= ndc_new;
      else          ndc_x_r <= ndc_new;
    end
  end

  assign stat.enable   = en_r;
  assign stat.div_done = div_done;
  assign stat.n_zero   = (nw_r == '0);

  assign cur_x  = cur_x_r;
  assign cur_y  = cur_y_r;
  assign prev_x = prev_x_r;
  assign prev_y = prev_y_r;
  assign ndc_x  = ndc_x_r;
  assign ndc_y  = ndc_y_r;

endmodule

// File: hdl/hjs_ctrl.sv
// controller state machine sequencing index, digit, fraction and ndc steps
module hjs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  hjs_pkg::dp_stat_t stat,
  output hjs_pkg::dp_cmd_t  cmd
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_IDX   = 13'b0000000000010,
    S_IDXW  = 13'b0000000000100,
    S_INIT  = 13'b0000000001000,
    S_DIG   = 13'b0000000010000,
    S_DIGW  = 13'b0000000100000,
    S_FRAC  = 13'b0000001000000,
    S_FRACW = 13'b0000010000000,
    S_MUL   = 13'b0000100000000,
    S_SCALE = 13'b0001000000000,
    S_NDC   = 13'b0010000000000,
    S_NDCW  = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   axis_r, axis_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    cmd       = '0;
    cmd.axis  = axis_r;
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.accept = 1'b1;
        state_nxt  = S_IDX;
      end
      S_IDX: if (!stat.enable) begin
        cmd.zero  = 1'b1;
        state_nxt = S_DONE;
      end else begin
        cmd.idx_start = 1'b1;
        state_nxt     = S_IDXW;
      end
      S_IDXW: if (stat.div_done) begin
        cmd.idx_done = 1'b1;
        axis_nxt     = 1'b0;
        state_nxt    = S_INIT;
      end
      S_INIT: begin
        cmd.axis_init = 1'b1;
        state_nxt     = S_DIG;
      end
      S_DIG: if (stat.n_zero) begin
        state_nxt = S_FRAC;
      end else begin
        cmd.dig_start = 1'b1;
        state_nxt     = S_DIGW;
      end
      S_DIGW: if (stat.div_done) begin
        cmd.dig_step = 1'b1;
        state_nxt    = S_DIG;
      end
      S_FRAC: begin
        cmd.frac_start = 1'b1;
        state_nxt      = S_FRACW;
      end
      S_FRACW: if (stat.div_done) begin
        cmd.frac_done = 1'b1;
        state_nxt     = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_NDC;
      end
      S_NDC: begin
        cmd.ndc_start = 1'b1;
        state_nxt     = S_NDCW;
      end
      S_NDCW: if (stat.div_done) begin
        cmd.ndc_done = 1'b1;
        if (axis_r) begin
          state_nxt = S_DONE;
        end else begin
          axis_nxt  = 1'b1;
          state_nxt = S_INIT;
        end
      end
      S_DONE: if (out_ready) begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule

// File: hdl/halton_jitter_sequence.sv
// top level: halton sub-pixel jitter generator with previous offset and ndc outputs
//
//  channel | ports                                  | beat
//  --------+----------------------------------------+------------------------------
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data | one register write
//  in      | in_valid in_ready in_jitter_enable     | one frame tick
//  out     | out_valid out_ready out_*              | offsets, previous, ndc
//
//  disabled beat: idle, index, then done, which raises out_valid
//  enabled beat: index mod, then per axis the digit loop (one step per digit of index+1),
//  fraction, multiply, scale and ndc, all divisions on the single shared bit-serial divider
//  one beat in flight; in_ready returns after the result beat is taken
//  synchronous active-low reset restores register defaults and clears state
module halton_jitter_sequence (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [hjs_pkg::CFG_W-1:0] cfg_index,
  input  logic [hjs_pkg::DAT_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_jitter_enable,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [hjs_pkg::OFS_W-1:0] out_offset_x,
  output logic signed [hjs_pkg::OFS_W-1:0] out_offset_y,
  output logic signed [hjs_pkg::OFS_W-1:0] out_prev_offset_x,
  output logic signed [hjs_pkg::OFS_W-1:0] out_prev_offset_y,
  output logic signed [hjs_pkg::OFS_W-1:0] out_ndc_x,
  output logic signed [hjs_pkg::OFS_W-1:0] out_ndc_y
);

  hjs_pkg::dp_cmd_t  cmd;
  hjs_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  hjs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  hjs_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_jitter_enable (in_jitter_enable),
    .cur_x            (out_offset_x),
    .cur_y            (out_offset_y),
    .prev_x           (out_prev_offset_x),
    .prev_y           (out_prev_offset_y),
    .ndc_x            (out_ndc_x),
    .ndc_y            (out_ndc_y)
  );

endmodule

// File: verif/tb_halton_jitter_sequence.sv
// self-checking testbench for the halton jitter sequence block
module tb_halton_jitter_sequence;

  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE      = 40;

  typedef struct packed {
    logic signed [hjs_pkg::OFS_W-1:0] ofs_x;
    logic signed [hjs_pkg::OFS_W-1:0] ofs_y;
    logic signed [hjs_pkg::OFS_W-1:0] prev_x;
    logic signed [hjs_pkg::OFS_W-1:0] prev_y;
    logic signed [hjs_pkg::OFS_W-1:0] ndc_x;
    logic signed [hjs_pkg::OFS_W-1:0] ndc_y;
  } jitter_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [hjs_pkg::CFG_W-1:0] cfg_index = '0;
  logic [hjs_pkg::DAT_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_jitter_enable = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [hjs_pkg::OFS_W-1:0] out_offset_x, out_offset_y;
  logic signed [hjs_pkg::OFS_W-1:0] out_prev_offset_x, out_prev_offset_y;
  logic signed [hjs_pkg::OFS_W-1:0] out_ndc_x, out_ndc_y;

  halton_jitter_sequence uut (.*);

  always #6 clk = ~clk;

  // predictor registers and state
  int unsigned m_len, m_bx, m_by, m_spread, m_pin_en, m_pin, m_width, m_height;
  int unsigned m_index;
  int m_cur_x, m_cur_y;

  jitter_beat_t beats_due[$];
  int errors = 0;
  int frames_sent = 0;
  int beats_checked = 0;
  int cfg_writes = 0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;
  int stall_cnt = 0;

  function automatic longint unsigned radical_frac(int unsigned n, int unsigned b);
    longint unsigned num, den, q;
    num = 0;
    den = 1;
    q = 0;
    while (n > 0) begin
      num = num * b + (n % b);
      den = den * b;
      n = n / b;
    end
    for (int i = 0; i < hjs_pkg::FRAC_W; i++) begin
      num = num << 1;
      q = q << 1;
      if (num >= den) begin
        num = num - den;
        q = q | 1;
      end
    end
    return q;
  endfunction

  function automatic int sat_q24(longint v);
    if (v > 64'sd8388607) return 8388607;
    if (v < -64'sd8388608) return -8388608;
    return int'(v);
  endfunction

  function automatic int axis_offset(int unsigned n, int unsigned b);
    longint diff;
    longint unsigned mag;
    diff = longint'(radical_frac(n, b)) - (64'sd1 <<< (hjs_pkg::FRAC_W - 1));
    mag = (diff < 0) ? -diff : diff;
    mag = (mag * m_spread) >> (hjs_pkg::FRAC_W - 4);
    return sat_q24((diff < 0) ? -longint'(mag) : longint'(mag));
  endfunction

  function automatic int ndc_of(int off, int unsigned dim);
    longint d;
    d = (dim == 0) ? 1 : dim;
    return sat_q24((longint'(off) * 2) / d);
  endfunction

  function automatic void predict_frame(bit en);
    int unsigned len, bx, by;
    jitter_beat_t e;
    len = (m_len == 0) ? 1 : m_len;
    bx = (m_bx < 2) ? 2 : m_bx;
    by = (m_by < 2) ? 2 : m_by;
    e.prev_x = m_cur_x[hjs_pkg::OFS_W-1:0];
    e.prev_y = m_cur_y[hjs_pkg::OFS_W-1:0];
    if (!en) begin
      m_cur_x = 0;
      m_cur_y = 0;
    end else begin
      if (m_pin_en != 0) m_index = (m_pin % len) & 16'hFFFF;
      else m_index = ((m_index + 1) % len) & 16'hFFFF;
      m_cur_x = axis_offset(m_index + 1, bx);
      m_cur_y = axis_offset(m_index + 1, by);
    end
    e.ofs_x = m_cur_x[hjs_pkg::OFS_W-1:0];
    e.ofs_y = m_cur_y[hjs_pkg::OFS_W-1:0];
    e.ndc_x = hjs_pkg::OFS_W'(ndc_of(m_cur_x, m_width));
    e.ndc_y = hjs_pkg::OFS_W'(ndc_of(m_cur_y, m_height));
    beats_due.push_back(e);
  endfunction

  function automatic void apply_reg(logic [hjs_pkg::CFG_W-1:0] idx,
                                    logic [hjs_pkg::DAT_W-1:0] d);
    case (idx)
      hjs_pkg::CFG_LEN:    m_len = 32'(d);
      hjs_pkg::CFG_BASE_X: m_bx = 32'(d[7:0]);
      hjs_pkg::CFG_BASE_Y: m_by = 32'(d[7:0]);
      hjs_pkg::CFG_SPREAD: m_spread = 32'(d);
      hjs_pkg::CFG_PIN_EN: m_pin_en = 32'(d[0]);
      hjs_pkg::CFG_PIN:    m_pin = 32'(d);
      hjs_pkg::CFG_WIDTH:  m_width = 32'(d);
      hjs_pkg::CFG_HEIGHT: m_height = 32'(d);
      default: ;
    endcase
  endfunction

  function automatic bit roll_idle();
    return !no_idle && ($urandom_range(99) < 34);
  endfunction

  // receiver side
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready <= !roll_idle();
    end
  end

  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (beats_due.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        jitter_beat_t e;
        e = beats_due.pop_front();
        beats_checked++;
        if (out_offset_x !== e.ofs_x) begin
          $error("offset_x exp %0d got %0d", e.ofs_x, out_offset_x); errors++;
        end
        if (out_offset_y !== e.ofs_y) begin
          $error("offset_y exp %0d got %0d", e.ofs_y, out_offset_y); errors++;
        end
        if (out_prev_offset_x !== e.prev_x) begin
          $error("prev_offset_x exp %0d got %0d", e.prev_x, out_prev_offset_x); errors++;
        end
        if (out_prev_offset_y !== e.prev_y) begin
          $error("prev_offset_y exp %0d got %0d", e.prev_y, out_prev_offset_y); errors++;
        end
        if (out_ndc_x !== e.ndc_x) begin
          $error("ndc_x exp %0d got %0d", e.ndc_x, out_ndc_x); errors++;
        end
        if (out_ndc_y !== e.ndc_y) begin
          $error("ndc_y exp %0d got %0d", e.ndc_y, out_ndc_y); errors++;
        end
      end
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
        || hold_req || !rst_n)
      stall_cnt <= 0;
    else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send_frame(bit en);
    @(negedge clk);
    while (roll_idle()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_jitter_enable <= en;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_frame(en);
    frames_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (beats_due.size() == 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic cfg_write(logic [hjs_pkg::CFG_W-1:0] idx, logic [hjs_pkg::DAT_W-1:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, d);
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_defaults();
    send_frame(1'b1);
    send_frame(1'b1);
    send_frame(1'b0);
    send_frame(1'b1);
    drain();
  endtask

  task automatic test_extremes();
    cfg_write(hjs_pkg::CFG_LEN, 16'd0);
    cfg_write(hjs_pkg::CFG_BASE_X, 16'd0);
    cfg_write(hjs_pkg::CFG_BASE_Y, 16'd1);
    cfg_write(hjs_pkg::CFG_SPREAD, 16'hFFFF);
    cfg_write(hjs_pkg::CFG_WIDTH, 16'd0);
    cfg_write(hjs_pkg::CFG_HEIGHT, 16'hFFFF);
    send_frame(1'b1);
    send_frame(1'b1);
    drain();
    cfg_write(hjs_pkg::CFG_LEN, 16'hFFFF);
    cfg_write(hjs_pkg::CFG_BASE_X, 16'hFFFF);
    cfg_write(hjs_pkg::CFG_BASE_Y, 16'd255);
    cfg_write(hjs_pkg::CFG_SPREAD, 16'd0);
    cfg_write(hjs_pkg::CFG_WIDTH, 16'hFFFF);
    cfg_write(hjs_pkg::CFG_HEIGHT, 16'd0);
    send_frame(1'b1);
    drain();
    // pinned index, also held across a disabled frame
    cfg_write(hjs_pkg::CFG_SPREAD, 16'hFFFF);
    cfg_write(hjs_pkg::CFG_BASE_X, 16'd2);
    cfg_write(hjs_pkg::CFG_PIN, 16'hFFFF);
    cfg_write(hjs_pkg::CFG_PIN_EN, 16'hFFFF);
    send_frame(1'b1);
    send_frame(1'b0);
    send_frame(1'b1);
    drain();
    cfg_write(hjs_pkg::CFG_LEN, 16'd5);
    cfg_write(hjs_pkg::CFG_PIN, 16'd12);
    send_frame(1'b1);
    drain();
    cfg_write(hjs_pkg::CFG_PIN_EN, 16'd0);
    // writes beyond the register list must not change anything
    for (int i = 8; i < 16; i++) cfg_write(i[hjs_pkg::CFG_W-1:0], 16'($urandom));
    // stale index after shrinking the length
    cfg_write(hjs_pkg::CFG_LEN, 16'd40);
    for (int i = 0; i < 6; i++) send_frame(1'b1);
    drain();
    cfg_write(hjs_pkg::CFG_LEN, 16'd3);
    send_frame(1'b1);
    send_frame(1'b1);
    drain();
  endtask

  task automatic random_config();
    int unsigned r;
    r = $urandom_range(9);
    cfg_write(hjs_pkg::CFG_LEN,
              (r == 0) ? 16'hFFFF : (r == 1) ? 16'd0 : 16'($urandom_range(1, 64)));
    cfg_write(hjs_pkg::CFG_BASE_X,
              ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7)));
    cfg_write(hjs_pkg::CFG_BASE_Y,
              ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7)));
    cfg_write(hjs_pkg::CFG_SPREAD, 16'($urandom));
    cfg_write(hjs_pkg::CFG_PIN_EN, ($urandom_range(4) == 0) ? 16'($urandom) : 16'h0);
    cfg_write(hjs_pkg::CFG_PIN,
              ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 80)));
    cfg_write(hjs_pkg::CFG_WIDTH,
              ($urandom_range(3) == 0) ? 16'($urandom_range(0, 4)) : 16'($urandom));
    cfg_write(hjs_pkg::CFG_HEIGHT,
              ($urandom_range(3) == 0) ? 16'($urandom_range(0, 4)) : 16'($urandom));
    if ($urandom_range(3) == 0)
      cfg_write(hjs_pkg::CFG_W'($urandom_range(8, 15)), 16'($urandom));
  endtask

  task automatic test_random();
    for (int p = 0; p < 14; p++) begin
      random_config();
      no_idle = (p == 5);
      for (int i = 0; i < 105; i++) begin
        send_frame($urandom_range(9) != 0);
        if ($urandom_range(60) == 0) begin
          // sender waits until every result is back
          @(negedge clk);
          in_valid <= 1'b0;
          wait (beats_due.size() == 0);
        end
      end
      no_idle = 1'b0;
      drain();
    end
  endtask

  task automatic test_backpressure();
    cfg_write(hjs_pkg::CFG_LEN, 16'd16);
    hold_req = 1'b1;
    for (int i = 0; i < 6; i++) send_frame(1'b1);
    drain();
  endtask

  initial begin
    apply_reg(hjs_pkg::CFG_LEN, 16'd8);
    apply_reg(hjs_pkg::CFG_BASE_X, 16'd2);
    apply_reg(hjs_pkg::CFG_BASE_Y, 16'd3);
    apply_reg(hjs_pkg::CFG_SPREAD, 16'd4096);
    apply_reg(hjs_pkg::CFG_PIN_EN, 16'd0);
    apply_reg(hjs_pkg::CFG_PIN, 16'd0);
    apply_reg(hjs_pkg::CFG_WIDTH, 16'd1);
    apply_reg(hjs_pkg::CFG_HEIGHT, 16'd1);
    m_index = 0;
    m_cur_x = 0;
    m_cur_y = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    repeat (SETTLE) @(negedge clk);
    test_defaults();
    test_extremes();
    test_backpressure();
    test_random();
    if (beats_due.size() != 0) begin
      $error("%0d result beats never arrived", beats_due.size());
      errors++;
    end
    $display("frames sent %0d, result beats checked %0d, register writes %0d",
             frames_sent, beats_checked, cfg_writes);
    $display("covered default, extreme, pinned, stale-index and random settings");
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
